[rtl/ttedl_pkg.sv]
// ----------------------------------------------------------------------------
// ttedl_pkg
// Shared widths, register indexes and reset values of the three-tap echo
// delay line.
// ----------------------------------------------------------------------------
package ttedl_pkg;

   // word widths
   localparam int SAMPLE_W    = 12;
   localparam int STORE_W     = 13;
   localparam int GAIN_W      = 16;
   localparam int DELAY_W     = 15;
   localparam int PROD_W      = GAIN_W + STORE_W;
   localparam int ACC_W       = 32;
   localparam int FRAC_SHIFT  = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // default ring size (power of two)
   localparam int RING_DEPTH_DEF = 32768;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MID_OFFSET      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DIRECT_GAIN     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TAP_ONE_GAIN    = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TAP_TWO_GAIN    = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TAP_THREE_GAIN  = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TAP_ONE_DELAY   = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TAP_TWO_DELAY   = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TAP_THREE_DELAY = 4'd7;

   // register reset values
   localparam logic [SAMPLE_W-1:0]      MID_OFFSET_RST      = 12'd1919;
   localparam logic signed [GAIN_W-1:0] DIRECT_GAIN_RST     = -16'sd22938;
   localparam logic signed [GAIN_W-1:0] TAP_ONE_GAIN_RST    = 16'sd16712;
   localparam logic signed [GAIN_W-1:0] TAP_TWO_GAIN_RST    = 16'sd11698;
   localparam logic signed [GAIN_W-1:0] TAP_THREE_GAIN_RST  = 16'sd8159;
   localparam logic [DELAY_W-1:0]       TAP_ONE_DELAY_RST   = 15'd22500;
   localparam logic [DELAY_W-1:0]       TAP_TWO_DELAY_RST   = 15'd20000;
   localparam logic [DELAY_W-1:0]       TAP_THREE_DELAY_RST = 15'd17500;

   // window of output codes that are passed to the DAC
   localparam int OUT_W = SAMPLE_W + 5;
   localparam logic signed [OUT_W-1:0] OUT_LOW  = 17'sd81;
   localparam logic signed [OUT_W-1:0] OUT_HIGH = 17'sd4095;

endpackage

[rtl/ttedl_ring.sv]
// ----------------------------------------------------------------------------
// ttedl_ring
// Single-port delay line store: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module ttedl_ring #(
   parameter int RING_DEPTH = ttedl_pkg::RING_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic                                  rd_en,
   input  logic [$clog2(RING_DEPTH)-1:0]         addr,
   input  logic signed [ttedl_pkg::STORE_W-1:0]  wdata,
   output logic signed [ttedl_pkg::STORE_W-1:0]  rdata
);
   import ttedl_pkg::*;

   logic signed [STORE_W-1:0] store_ff [RING_DEPTH];
   logic signed [STORE_W-1:0] rdata_ff;

   // one access per cycle, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wdata;
      end else if (rd_en) begin
         rdata_ff <= store_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/three_tap_echo_delay_line_core.sv]
// Output: a result word is registered at stage_ff[4], and only if it lies in the output window.
// The sample rate is set by the single-port ring (one write, three tap reads per sample);
// the arithmetic of one sample overlaps the memory work of the next.
// Reset: synchronous, clears the pipeline and output, loads default registers, rewinds the
// write pointer; a fill count makes never-written ring entries read as zero (no clear pass).
// ----------------------------------------------------------------------------
// three_tap_echo_delay_line_core
// Offset-removed samples go into a circular store; three delayed taps and the
// current sample are weighted by signed Q0.16 gains, scaled back and offset again.
// ----------------------------------------------------------------------------
module three_tap_echo_delay_line_core #(
   parameter int RING_DEPTH = ttedl_pkg::RING_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample words
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ttedl_pkg::SAMPLE_W-1:0]       req_sample,
   // result words
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ttedl_pkg::SAMPLE_W-1:0]       rsp_dac_value,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ttedl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ttedl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ttedl_pkg::*;

   localparam int AW   = $clog2(RING_DEPTH);
   localparam int SUBW = (AW > DELAY_W) ? AW : DELAY_W;

   // configuration registers
   logic [SAMPLE_W-1:0]      mid_offset_ff;
   logic signed [GAIN_W-1:0] direct_gain_ff;
   logic signed [GAIN_W-1:0] tap_one_gain_ff;
   logic signed [GAIN_W-1:0] tap_two_gain_ff;
   logic signed [GAIN_W-1:0] tap_three_gain_ff;
   logic [DELAY_W-1:0]       tap_one_delay_ff;
   logic [DELAY_W-1:0]       tap_two_delay_ff;
   logic [DELAY_W-1:0]       tap_three_delay_ff;

   // pipeline state
   logic [4:0]               stage_ff;
   logic [4:0]               stage_in;
   logic [AW-1:0]            wp_ff;
   logic [AW:0]              fill_ff;
   logic [AW-1:0]            item_wp_ff;
   logic signed [STORE_W-1:0] cur_ff;
   logic                     tap_ok_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     rsp_valid_ff;
   logic [SAMPLE_W-1:0]      rsp_data_ff;

   // combinational signals
   logic                     adv;
   logic                     accept;
   logic signed [STORE_W-1:0] cur_in;
   logic [DELAY_W-1:0]       tap_delay;
   logic [SUBW-1:0]          tap_diff;
   logic [AW-1:0]            tap_addr;
   logic                     ring_we;
   logic                     ring_re;
   logic [AW-1:0]            ring_addr;
   logic signed [STORE_W-1:0] ring_rdata;
   logic signed [STORE_W-1:0] tap_data;
   logic signed [GAIN_W-1:0] mul_gain;
   logic signed [STORE_W-1:0] mul_data;
   logic signed [ACC_W-1:0]  sum_final;
   logic signed [GAIN_W-1:0] quot;
   logic signed [OUT_W-1:0]  out_value;
   logic                     out_in_range;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_offset_ff      <= MID_OFFSET_RST;
         direct_gain_ff     <= DIRECT_GAIN_RST;
         tap_one_gain_ff    <= TAP_ONE_GAIN_RST;
         tap_two_gain_ff    <= TAP_TWO_GAIN_RST;
         tap_three_gain_ff  <= TAP_THREE_GAIN_RST;
         tap_one_delay_ff   <= TAP_ONE_DELAY_RST;
         tap_two_delay_ff   <= TAP_TWO_DELAY_RST;
         tap_three_delay_ff <= TAP_THREE_DELAY_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MID_OFFSET:      mid_offset_ff      <= csr_wdata[SAMPLE_W-1:0];
            REG_DIRECT_GAIN:     direct_gain_ff     <= $signed(csr_wdata);
            REG_TAP_ONE_GAIN:    tap_one_gain_ff    <= $signed(csr_wdata);
            REG_TAP_TWO_GAIN:    tap_two_gain_ff    <= $signed(csr_wdata);
            REG_TAP_THREE_GAIN:  tap_three_gain_ff  <= $signed(csr_wdata);
            REG_TAP_ONE_DELAY:   tap_one_delay_ff   <= csr_wdata[DELAY_W-1:0];
            REG_TAP_TWO_DELAY:   tap_two_delay_ff   <= csr_wdata[DELAY_W-1:0];
            REG_TAP_THREE_DELAY: tap_three_delay_ff <= csr_wdata[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // flow control: the whole pipeline freezes only when a result would be lost
   always_comb begin
      adv       = !(stage_ff[4] && rsp_valid_ff && rsp_stall);
      req_stall = !adv || (|stage_ff[2:0]);
      accept    = req_valid && !req_stall;
      stage_in  = {stage_ff[3:0], accept};
   end

   // offset removal
   assign cur_in = $signed({1'b0, req_sample}) - $signed({1'b0, mid_offset_ff});

   // tap address for the stage about to read
   always_comb begin
      if (stage_ff[0]) begin
         tap_delay = tap_one_delay_ff;
      end else if (stage_ff[1]) begin
         tap_delay = tap_two_delay_ff;
      end else begin
         tap_delay = tap_three_delay_ff;
      end
      tap_diff = SUBW'(item_wp_ff) - SUBW'(tap_delay);
      tap_addr = tap_diff[AW-1:0];
   end

   // ring access: write on accept, tap reads in the three stages after
   always_comb begin
      ring_we   = accept;
      ring_re   = adv && (|stage_ff[2:0]);
      ring_addr = accept ? wp_ff : tap_addr;
   end

   ttedl_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .wr_en (ring_we),
      .rd_en (ring_re),
      .addr  (ring_addr),
      .wdata (cur_in),
      .rdata (ring_rdata)
   );

   // entries past the fill count were never written and read as zero
   assign tap_data = tap_ok_ff ? ring_rdata : '0;

   // shared multiplier operand select
   always_comb begin
      if (stage_ff[0]) begin
         mul_gain = direct_gain_ff;
         mul_data = cur_ff;
      end else if (stage_ff[1]) begin
         mul_gain = tap_one_gain_ff;
         mul_data = tap_data;
      end else if (stage_ff[2]) begin
         mul_gain = tap_two_gain_ff;
         mul_data = tap_data;
      end else begin
         mul_gain = tap_three_gain_ff;
         mul_data = tap_data;
      end
      prod_in = mul_gain * mul_data;
   end

   // final sum, floor shift and offset back
   always_comb begin
      sum_final    = acc_ff + ACC_W'(prod_ff);
      quot         = sum_final[ACC_W-1:FRAC_SHIFT];
      out_value    = OUT_W'(quot) + $signed({5'b0, mid_offset_ff});
      out_in_range = (out_value >= OUT_LOW) && (out_value <= OUT_HIGH);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         wp_ff    <= '0;
         fill_ff  <= '0;
      end else if (adv) begin
         stage_ff <= stage_in;
         if (accept) begin
            wp_ff <= wp_ff + AW'(1);
            if (fill_ff != (AW+1)'(RING_DEPTH)) begin
               fill_ff <= fill_ff + (AW+1)'(1);
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         if (accept) begin
            item_wp_ff <= wp_ff;
            cur_ff     <= cur_in;
         end
         if (ring_re) begin
            tap_ok_ff <= ({1'b0, tap_addr} < fill_ff);
         end
         if (|stage_ff[3:0]) begin
            prod_ff <= prod_in;
         end
         if (stage_ff[1]) begin
            acc_ff <= ACC_W'(prod_ff);
         end else if (stage_ff[2] || stage_ff[3]) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && stage_ff[4] && out_in_range) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && stage_ff[4] && out_in_range) begin
         rsp_data_ff <= out_value[SAMPLE_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dac_value = rsp_data_ff;

   // checks
   a_single_mem_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0(stage_ff[3:0]))
      else $error("more than one word in the ring phase");

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ring_we && ring_re))
      else $error("ring read and write in one cycle");

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("sample taken while ring still busy");

   a_out_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dac_value >= 12'd81))
      else $error("result word below the output window");

endmodule
